### rtl/core/saes_pkg.sv
// Shared types, constants and cipher functions for the S-AES block.
package saes_pkg;

  localparam int BLOCK_W = 16;
  localparam int NIB_W   = 4;
  localparam int APB_AW  = 2;
  localparam int APB_DW  = 32;

  localparam logic [APB_AW-1:0] ADDR_CIPHER_KEY = 2'd0;

  localparam logic [7:0] RCON1 = 8'h80;
  localparam logic [7:0] RCON2 = 8'h30;

  localparam logic [NIB_W-1:0] ENC_DIAG = 4'h1;
  localparam logic [NIB_W-1:0] ENC_OFF  = 4'h4;
  localparam logic [NIB_W-1:0] DEC_DIAG = 4'h9;
  localparam logic [NIB_W-1:0] DEC_OFF  = 4'h2;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } op_t;

  typedef logic [BLOCK_W-1:0] block_t;

  typedef struct packed {
    block_t k0;
    block_t k1;
    block_t k2;
  } round_keys_t;

  function automatic logic [NIB_W-1:0] sbox_fwd(logic [NIB_W-1:0] x);
    logic [NIB_W-1:0] r;
    case (x)
      4'h0: r = 4'h9;
      4'h1: r = 4'h4;
      4'h2: r = 4'hA;
      4'h3: r = 4'hB;
      4'h4: r = 4'hD;
      4'h5: r = 4'h1;
      4'h6: r = 4'h8;
      4'h7: r = 4'h5;
      4'h8: r = 4'h6;
      4'h9: r = 4'h2;
      4'hA: r = 4'h0;
      4'hB: r = 4'h3;
      4'hC: r = 4'hC;
      4'hD: r = 4'hE;
      4'hE: r = 4'hF;
      4'hF: r = 4'h7;
      default: r = 4'h0;
    endcase
    return r;
  endfunction

  function automatic logic [NIB_W-1:0] sbox_inv(logic [NIB_W-1:0] x);
    logic [NIB_W-1:0] r;
    case (x)
      4'h0: r = 4'hA;
      4'h1: r = 4'h5;
      4'h2: r = 4'h9;
      4'h3: r = 4'hB;
      4'h4: r = 4'h1;
      4'h5: r = 4'h7;
      4'h6: r = 4'h8;
      4'h7: r = 4'hF;
      4'h8: r = 4'h6;
      4'h9: r = 4'h0;
      4'hA: r = 4'h2;
      4'hB: r = 4'h3;
      4'hC: r = 4'hC;
      4'hD: r = 4'h4;
      4'hE: r = 4'hD;
      4'hF: r = 4'hE;
      default: r = 4'h0;
    endcase
    return r;
  endfunction

  // GF(16) multiply modulo x^4 + x + 1
  function automatic logic [NIB_W-1:0] gf_mul(logic [NIB_W-1:0] a, logic [NIB_W-1:0] b);
    logic [NIB_W-1:0] p;
    logic [NIB_W-1:0] aa;
    p  = '0;
    aa = a;
    for (int i = 0; i < NIB_W; i++) begin
      if (b[i]) begin
        p = p ^ aa;
      end
      aa = aa[NIB_W-1] ? ({aa[NIB_W-2:0], 1'b0} ^ 4'h3) : {aa[NIB_W-2:0], 1'b0};
    end
    return p;
  endfunction

  function automatic block_t sub_fwd(block_t v);
    return {sbox_fwd(v[15:12]), sbox_fwd(v[11:8]), sbox_fwd(v[7:4]), sbox_fwd(v[3:0])};
  endfunction

  function automatic block_t sub_inv(block_t v);
    return {sbox_inv(v[15:12]), sbox_inv(v[11:8]), sbox_inv(v[7:4]), sbox_inv(v[3:0])};
  endfunction

  function automatic block_t shift_rows(block_t v);
    return {v[15:12], v[3:0], v[7:4], v[11:8]};
  endfunction

  function automatic block_t mix_cols(block_t v, logic [NIB_W-1:0] d, logic [NIB_W-1:0] o);
    return {gf_mul(d, v[15:12]) ^ gf_mul(o, v[11:8]),
            gf_mul(o, v[15:12]) ^ gf_mul(d, v[11:8]),
            gf_mul(d, v[7:4])   ^ gf_mul(o, v[3:0]),
            gf_mul(o, v[7:4])   ^ gf_mul(d, v[3:0])};
  endfunction

  function automatic logic [7:0] key_word(logic [7:0] even, logic [7:0] odd,
                                          logic [7:0] rcon);
    return even ^ rcon ^ {sbox_fwd(odd[3:0]), sbox_fwd(odd[7:4])};
  endfunction

  function automatic round_keys_t expand_key(block_t key);
    logic [7:0] w2;
    logic [7:0] w3;
    logic [7:0] w4;
    logic [7:0] w5;
    round_keys_t rk;
    w2 = key_word(key[15:8], key[7:0], RCON1);
    w3 = w2 ^ key[7:0];
    w4 = key_word(w2, w3, RCON2);
    w5 = w4 ^ w3;
    rk.k0 = key;
    rk.k1 = {w2, w3};
    rk.k2 = {w4, w5};
    return rk;
  endfunction

endpackage

### rtl/core/saes_if.sv
// Valid/ready channel interfaces for S-AES input and result words.
interface saes_item_if;
  logic                   valid;
  logic                   ready;
  saes_pkg::op_t          operation;
  saes_pkg::block_t       data_in;

  modport source (output valid, output operation, output data_in, input ready);
  modport sink   (input valid, input operation, input data_in, output ready);
endinterface

interface saes_result_if;
  logic             valid;
  logic             ready;
  saes_pkg::block_t data_out;

  modport source (output valid, output data_out, input ready);
  modport sink   (input valid, input data_out, output ready);
endinterface

### rtl/core/saes_regs.sv
// APB key register with registered round-key expansion.
module saes_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [saes_pkg::APB_AW-1:0]   paddr,
  input  logic [saes_pkg::APB_DW-1:0]   pwdata,
  output logic [saes_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output saes_pkg::round_keys_t         round_keys
);
  import saes_pkg::*;

  block_t      cipher_key;
  logic        key_wr;

  assign pready = 1'b1;
  assign key_wr = psel && penable && pwrite && (paddr == ADDR_CIPHER_KEY);

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key <= '0;
      round_keys <= expand_key('0);
    end else if (key_wr) begin
      cipher_key <= pwdata[BLOCK_W-1:0];
      round_keys <= expand_key(pwdata[BLOCK_W-1:0]);
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_CIPHER_KEY) begin
      prdata = {{(APB_DW-BLOCK_W){1'b0}}, cipher_key};
    end
  end

endmodule

### rtl/core/saes_cipher.sv
// Combinational two-round S-AES encrypt/decrypt datapath.
module saes_cipher (
  input  saes_pkg::op_t         operation,
  input  saes_pkg::block_t      data_in,
  input  saes_pkg::round_keys_t round_keys,
  output saes_pkg::block_t      data_out
);
  import saes_pkg::*;

  block_t enc;
  block_t dec;

  always_comb begin
    enc = data_in ^ round_keys.k0;
    enc = mix_cols(shift_rows(sub_fwd(enc)), ENC_DIAG, ENC_OFF) ^ round_keys.k1;
    enc = shift_rows(sub_fwd(enc)) ^ round_keys.k2;

    dec = data_in ^ round_keys.k2;
    dec = sub_inv(shift_rows(dec)) ^ round_keys.k1;
    dec = mix_cols(dec, DEC_DIAG, DEC_OFF);
    dec = sub_inv(shift_rows(dec)) ^ round_keys.k0;
  end

  assign data_out = (operation == OP_DECRYPT) ? dec : enc;

endmodule

### rtl/core/simplified_aes_block_cipher.sv
// S-AES block cipher, 16-bit block and key, one block per cycle unless the
// result side stalls. Each input word carries an operation (encrypt or
// decrypt) and a block; it is captured in an input register, the full
// two-round cipher is evaluated combinationally, and the result lands in an
// output register, which holds while a valid result is not taken; a full
// input register then holds too. The key is written over APB at address 0;
// round keys are expanded at the write, so a new key applies to words
// accepted at or after the write edge. Change the key only while no word is
// in flight.
module simplified_aes_block_cipher (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [saes_pkg::APB_AW-1:0]   paddr,
  input  logic [saes_pkg::APB_DW-1:0]   pwdata,
  output logic [saes_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  saes_item_if.sink                     item,
  saes_result_if.source                 result
);
  import saes_pkg::*;

  round_keys_t round_keys;
  logic        s1_valid;
  op_t         s1_op;
  block_t      s1_data;
  block_t      cipher_out;
  logic        out_valid;
  block_t      out_data;
  logic        out_adv;

  saes_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .round_keys (round_keys)
  );

  saes_cipher u_cipher (
    .operation  (s1_op),
    .data_in    (s1_data),
    .round_keys (round_keys),
    .data_out   (cipher_out)
  );

  assign out_adv         = !out_valid || result.ready;
  assign item.ready      = !s1_valid || out_adv;
  assign result.valid    = out_valid;
  assign result.data_out = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (item.ready) begin
        s1_valid <= item.valid;
      end
      if (out_adv) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_op   <= item.operation;
      s1_data <= item.data_in;
    end
    if (out_adv && s1_valid) begin
      out_data <= cipher_out;
    end
  end

endmodule
